@@ hw/rtl/qoi_pixel_stream_decoder_core_macros.svh @@
// Assertion helpers shared by the decoder modules.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef QOI_PIXEL_STREAM_DECODER_CORE_MACROS_SVH
`define QOI_PIXEL_STREAM_DECODER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QOI_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define QOI_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/qoi_pkg.sv @@
`default_nettype none

package qoi_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int TABLE_AW    = $clog2(TABLE_DEPTH);

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = FIFO_AW + 1;

  localparam logic [7:0] TAG_RGB  = 8'hFE;
  localparam logic [7:0] TAG_RGBA = 8'hFF;

  localparam logic [1:0] OP_INDEX = 2'b00;
  localparam logic [1:0] OP_DIFF  = 2'b01;
  localparam logic [1:0] OP_LUMA  = 2'b10;
  localparam logic [1:0] OP_RUN   = 2'b11;

  localparam logic [2:0] PHASE_TAG  = 3'd0;
  localparam logic [2:0] PHASE_LUMA = 3'd1;
  localparam logic [2:0] PHASE_RGB  = 3'd3;
  localparam logic [2:0] PHASE_RGBA = 3'd4;

  localparam logic [7:0] DIFF_BIAS   = 8'd2;
  localparam logic [7:0] LUMA_BIAS_G = 8'd32;
  localparam logic [7:0] LUMA_BIAS_RB = 8'd8;

  localparam logic        REG_IMAGE_PIXELS   = 1'b0;
  localparam logic [31:0] IMAGE_PIXELS_RESET = 32'd1;

  typedef enum logic [2:0] {
    CMD_INDEX,
    CMD_DIFF,
    CMD_LUMA,
    CMD_RGB,
    CMD_RGBA,
    CMD_RUN
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [31:0] data;
  } cmd_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pixel_t;

  localparam pixel_t PIXEL_RESET = '{red: 8'h00, green: 8'h00, blue: 8'h00, alpha: 8'hFF};

  typedef enum logic [1:0] {
    B_IDLE,
    B_INDEX,
    B_RUN
  } back_state_t;

  function automatic logic [TABLE_AW-1:0] pixel_hash(input pixel_t p);
    logic [5:0] r;
    logic [5:0] g;
    logic [5:0] b;
    logic [5:0] a;
    logic [5:0] h;
    r = p.red[5:0];
    g = p.green[5:0];
    b = p.blue[5:0];
    a = p.alpha[5:0];
    h = (r + {r[4:0], 1'b0}) + (g + {g[3:0], 2'b00}) + ({b[2:0], 3'b000} - b)
        + ({a[2:0], 3'b000} + {a[4:0], 1'b0} + a);
    return h;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/qoi_front.sv @@
`default_nettype none

module qoi_front import qoi_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       restart,
  input  logic       byte_valid,
  output logic       byte_ready,
  input  logic [7:0] stream_byte,
  output logic       cmd_push,
  output cmd_t       cmd,
  input  logic       cmd_full
);

  logic [2:0]  phase;
  logic [2:0]  phase_next;
  logic [7:0]  pending;
  logic [7:0]  pending_next;
  logic [23:0] gathered;
  logic [23:0] gathered_next;
  logic        take;

  assign byte_ready = !cmd_full;
  assign take       = byte_valid && byte_ready;

  always_comb begin
    phase_next    = phase;
    pending_next  = pending;
    gathered_next = gathered;
    cmd_push      = 1'b0;
    cmd.kind      = CMD_DIFF;
    cmd.data      = '0;
    if (take) begin
      if (phase != PHASE_TAG) begin
        phase_next    = phase - 3'd1;
        gathered_next = {gathered[15:0], stream_byte};
        if (phase == 3'd1) begin
          cmd_push      = 1'b1;
          gathered_next = '0;
          pending_next  = '0;
          if (pending == TAG_RGB) begin
            cmd.kind = CMD_RGB;
            cmd.data = {gathered, stream_byte};
          end else if (pending == TAG_RGBA) begin
            cmd.kind = CMD_RGBA;
            cmd.data = {gathered, stream_byte};
          end else begin
            cmd.kind = CMD_LUMA;
            cmd.data = {16'h0000, pending, stream_byte};
          end
        end
      end else if (stream_byte == TAG_RGB || stream_byte == TAG_RGBA) begin
        pending_next  = stream_byte;
        gathered_next = '0;
        phase_next    = (stream_byte == TAG_RGB) ? PHASE_RGB : PHASE_RGBA;
      end else begin
        case (stream_byte[7:6])
          OP_INDEX: begin
            cmd_push = 1'b1;
            cmd.kind = CMD_INDEX;
            cmd.data = {26'h0, stream_byte[5:0]};
          end
          OP_DIFF: begin
            cmd_push = 1'b1;
            cmd.kind = CMD_DIFF;
            cmd.data = {24'h0, stream_byte};
          end
          OP_LUMA: begin
            pending_next  = stream_byte;
            gathered_next = '0;
            phase_next    = PHASE_LUMA;
          end
          OP_RUN: begin
            cmd_push = 1'b1;
            cmd.kind = CMD_RUN;
            cmd.data = {26'h0, stream_byte[5:0]};
          end
          default: begin
            cmd_push = 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      phase    <= PHASE_TAG;
      pending  <= '0;
      gathered <= '0;
    end else begin
      phase    <= phase_next;
      pending  <= pending_next;
      gathered <= gathered_next;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/qoi_cmd_fifo.sv @@
`default_nettype none
`include "qoi_pixel_stream_decoder_core_macros.svh"

module qoi_cmd_fifo import qoi_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t pop_cmd,
  output logic empty
);

  cmd_t               entries [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_CW-1:0] count;

  assign full    = (count == FIFO_CW'(FIFO_DEPTH));
  assign empty   = (count == '0);
  assign pop_cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      if (push && !pop) begin
        count <= count + FIFO_CW'(1);
      end else if (pop && !push) begin
        count <= count - FIFO_CW'(1);
      end
    end
  end

  `QOI_ASSERT_IMP(a_fifo_no_overflow, push && !pop, !full, "command queue written while full")
  `QOI_ASSERT_IMP(a_fifo_no_underflow, pop, !empty, "command queue read while empty")

endmodule

`default_nettype wire

@@ hw/rtl/qoi_back.sv @@
`default_nettype none
`include "qoi_pixel_stream_decoder_core_macros.svh"

module qoi_back import qoi_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        restart,
  input  logic [31:0] restart_pixels,
  input  logic [31:0] image_pixels,
  input  logic        cmd_valid,
  input  cmd_t        cmd,
  output logic        cmd_pop,
  output logic        pixel_valid,
  input  logic        pixel_ready,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [7:0]  alpha,
  output logic        last_of_burst,
  output logic        image_end
);

  back_state_t         state;
  back_state_t         state_next;
  pixel_t              prev;
  logic [31:0]         remaining;
  logic [TABLE_DEPTH-1:0] tbl_valid;
  pixel_t              mem [TABLE_DEPTH];
  pixel_t              rd_data;
  logic                rd_valid;
  logic [5:0]          run_left;

  logic                out_free;
  logic                emit;
  logic                emit_last;
  logic                fin;
  logic                rd_issue;
  pixel_t              pix;
  pixel_t              diff_pix;
  pixel_t              luma_pix;
  logic [TABLE_AW-1:0] wr_idx;
  logic [TABLE_AW-1:0] rd_idx;
  logic [7:0]          dg;

  assign out_free = !pixel_valid || pixel_ready;
  assign fin      = (remaining == 32'd1);
  assign wr_idx   = pixel_hash(pix);
  assign rd_idx   = cmd.data[TABLE_AW-1:0];

  always_comb begin
    diff_pix.red   = prev.red + {6'b0, cmd.data[5:4]} - DIFF_BIAS;
    diff_pix.green = prev.green + {6'b0, cmd.data[3:2]} - DIFF_BIAS;
    diff_pix.blue  = prev.blue + {6'b0, cmd.data[1:0]} - DIFF_BIAS;
    diff_pix.alpha = prev.alpha;
    dg             = {2'b00, cmd.data[13:8]} - LUMA_BIAS_G;
    luma_pix.red   = prev.red + dg + {4'h0, cmd.data[7:4]} - LUMA_BIAS_RB;
    luma_pix.green = prev.green + dg;
    luma_pix.blue  = prev.blue + dg + {4'h0, cmd.data[3:0]} - LUMA_BIAS_RB;
    luma_pix.alpha = prev.alpha;
  end

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (cmd_pop && cmd.kind == CMD_INDEX) begin
          state_next = B_INDEX;
        end else if (cmd_pop && cmd.kind == CMD_RUN) begin
          state_next = B_RUN;
        end
      end
      B_INDEX: begin
        if (emit) begin
          state_next = B_IDLE;
        end
      end
      B_RUN: begin
        if (emit && (emit_last || fin)) begin
          state_next = B_IDLE;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_pop   = 1'b0;
    emit      = 1'b0;
    emit_last = 1'b1;
    rd_issue  = 1'b0;
    pix       = prev;
    case (state)
      B_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_pop = 1'b1;
          case (cmd.kind)
            CMD_INDEX: begin
              rd_issue = 1'b1;
            end
            CMD_DIFF: begin
              emit = 1'b1;
              pix  = diff_pix;
            end
            CMD_LUMA: begin
              emit = 1'b1;
              pix  = luma_pix;
            end
            CMD_RGB: begin
              emit = 1'b1;
              pix  = '{red: cmd.data[23:16], green: cmd.data[15:8],
                       blue: cmd.data[7:0], alpha: prev.alpha};
            end
            CMD_RGBA: begin
              emit = 1'b1;
              pix  = cmd.data;
            end
            default: begin
              emit = 1'b0;
            end
          endcase
        end
      end
      B_INDEX: begin
        if (out_free) begin
          emit = 1'b1;
          pix  = rd_valid ? rd_data : '0;
        end
      end
      B_RUN: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_last = (run_left == 6'd0);
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      mem[wr_idx] <= pix;
    end
    if (rd_issue) begin
      rd_data <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_issue) begin
      rd_valid <= tbl_valid[rd_idx];
    end
    if (cmd_pop && cmd.kind == CMD_RUN) begin
      run_left <= cmd.data[5:0];
    end else if (emit && state == B_RUN) begin
      run_left <= run_left - 6'd1;
    end
    if (emit) begin
      {red, green, blue, alpha} <= pix;
      last_of_burst <= emit_last || fin;
      image_end     <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= B_IDLE;
      prev        <= PIXEL_RESET;
      remaining   <= IMAGE_PIXELS_RESET;
      tbl_valid   <= '0;
      pixel_valid <= 1'b0;
    end else if (restart) begin
      state       <= B_IDLE;
      prev        <= PIXEL_RESET;
      remaining   <= restart_pixels;
      tbl_valid   <= '0;
      pixel_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        pixel_valid <= 1'b1;
      end else if (pixel_ready) begin
        pixel_valid <= 1'b0;
      end
      if (emit) begin
        if (fin) begin
          prev      <= PIXEL_RESET;
          remaining <= image_pixels;
          tbl_valid <= '0;
        end else begin
          prev              <= pix;
          remaining         <= remaining - 32'd1;
          tbl_valid[wr_idx] <= 1'b1;
        end
      end
    end
  end

  `QOI_ASSERT_IMP(a_back_end_is_last, pixel_valid && image_end, last_of_burst,
                  "image end without end of burst")
  `QOI_ASSERT_IMP(a_back_pop_idle, cmd_pop, state == B_IDLE && cmd_valid,
                  "command taken while a command is in progress")
  `QOI_ASSERT_NXT(a_back_reload, emit && fin && !restart,
                  remaining == $past(image_pixels), "pixel count not reloaded at image end")

endmodule

`default_nettype wire

@@ hw/rtl/qoi_pixel_stream_decoder_core.sv @@
// A one-byte DIFF chunk or the last byte of a LUMA, RGB or RGBA chunk is written into the
// command queue, popped by the pixel unit and registered at the pixel outputs; an INDEX
// chunk also passes the table-read state and a RUN the run state. Bytes enter at one per
// cycle while the four-entry command queue has room; the pixel unit pops a command only while
// its output is free, and emits a RUN one pixel at a time. Reset is synchronous; the color
// table reads as zero through per-entry valid bits, so no clearing pass is needed.
`default_nettype none

module qoi_pixel_stream_decoder_core import qoi_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        byte_valid,
  output logic        byte_ready,
  input  logic [7:0]  stream_byte,
  output logic        pixel_valid,
  input  logic        pixel_ready,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [7:0]  alpha,
  output logic        last_of_burst,
  output logic        image_end
);

  logic [31:0] image_pixels;
  logic        restart;
  logic        cmd_push;
  cmd_t        push_cmd;
  logic        cmd_full;
  logic        cmd_pop;
  cmd_t        pop_cmd;
  logic        cmd_empty;

  assign pready  = 1'b1;
  assign restart = psel && penable && pwrite && pready && (paddr[2] == REG_IMAGE_PIXELS);
  assign prdata  = (paddr[2] == REG_IMAGE_PIXELS) ? image_pixels : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_pixels <= IMAGE_PIXELS_RESET;
    end else if (restart) begin
      image_pixels <= pwdata;
    end
  end

  qoi_front u_front (
    .clk         (clk),
    .rst         (rst),
    .restart     (restart),
    .byte_valid  (byte_valid),
    .byte_ready  (byte_ready),
    .stream_byte (stream_byte),
    .cmd_push    (cmd_push),
    .cmd         (push_cmd),
    .cmd_full    (cmd_full)
  );

  qoi_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (cmd_push),
    .push_cmd (push_cmd),
    .full     (cmd_full),
    .pop      (cmd_pop),
    .pop_cmd  (pop_cmd),
    .empty    (cmd_empty)
  );

  qoi_back u_back (
    .clk            (clk),
    .rst            (rst),
    .restart        (restart),
    .restart_pixels (pwdata),
    .image_pixels   (image_pixels),
    .cmd_valid      (!cmd_empty),
    .cmd            (pop_cmd),
    .cmd_pop        (cmd_pop),
    .pixel_valid    (pixel_valid),
    .pixel_ready    (pixel_ready),
    .red            (red),
    .green          (green),
    .blue           (blue),
    .alpha          (alpha),
    .last_of_burst  (last_of_burst),
    .image_end      (image_end)
  );

endmodule

`default_nettype wire
